// File: design/swdp_pkg.sv
// ----------------------------------------------------------------------------
// swdp_pkg
// Shared types and constants for the four-coil wave-drive stepper positioner.
// ----------------------------------------------------------------------------
package swdp_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned PosW      = 16;
  localparam int unsigned IntervalW = 15;
  localparam int unsigned CoilN     = 4;
  localparam int unsigned PhaseW    = 2;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned InDataW   = 72;
  localparam int unsigned OutDataW  = 24;

  // Command carried on the input tuser bit.
  typedef enum logic {
    CMD_STEP = 1'b0,
    CMD_LOAD = 1'b1
  } swdp_cmd_e;

  // One input item after unpacking.
  typedef struct packed {
    swdp_cmd_e               cmd;
    logic [TimeW-1:0]        now_ms;
    logic signed [PosW-1:0]  target_position;
    logic                    auto_enable;
    logic                    manual_up;
    logic signed [PosW-1:0]  new_position;
  } swdp_item_t;

  // One result item.
  typedef struct packed {
    logic signed [PosW-1:0]  position;
    logic [CoilN-1:0]        coil_drive;
  } swdp_result_t;

endpackage

// File: design/swdp_core.sv
// ----------------------------------------------------------------------------
// swdp_core
// Step decision and motor state: position, phase, coil pattern and the time
// of the last step. Computes the result of one item combinationally.
// ----------------------------------------------------------------------------
module swdp_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  swdp_pkg::swdp_item_t            item_i,
  input  logic [swdp_pkg::IntervalW-1:0]  interval_i,
  output swdp_pkg::swdp_result_t          result_o
);
  import swdp_pkg::*;

  logic signed [PosW-1:0]  pos_q, pos_d;
  logic [TimeW-1:0]        last_q, last_d;
  logic [PhaseW-1:0]       phase_q, phase_d;
  logic [CoilN-1:0]        coil_q, coil_d;

  logic                    idle;
  logic                    up;
  logic                    step_due;
  logic [TimeW-1:0]        elapsed;
  logic [CoilN-1:0]        phase_bit;

  // Direction, idle detection and the interval check with wrapping time.
  assign idle      = item_i.auto_enable && (pos_q == item_i.target_position);
  assign up        = item_i.auto_enable ? !(pos_q > item_i.target_position)
                                        : item_i.manual_up;
  assign elapsed   = item_i.now_ms - last_q;
  assign step_due  = elapsed >= {{(TimeW-IntervalW){1'b0}}, interval_i};
  assign phase_bit = CoilN'(1) << phase_q;

  // Next state for this item.
  always_comb begin
    pos_d   = pos_q;
    last_d  = last_q;
    phase_d = phase_q;
    coil_d  = coil_q;
    case (item_i.cmd)
      CMD_LOAD: begin
        pos_d = item_i.new_position;
      end
      CMD_STEP: begin
        if (!idle) begin
          coil_d = coil_q | phase_bit;
          if (step_due) begin
            last_d  = item_i.now_ms;
            pos_d   = up ? pos_q + PosW'(1) : pos_q - PosW'(1);
            coil_d  = coil_q & ~phase_bit;
            phase_d = up ? phase_q - PhaseW'(1) : phase_q + PhaseW'(1);
          end
        end
      end
      default: begin
        pos_d = pos_q;
      end
    endcase
  end

  // Motor state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      last_q  <= '0;
      phase_q <= '0;
      coil_q  <= '0;
    end else if (en_i) begin
      pos_q   <= pos_d;
      last_q  <= last_d;
      phase_q <= phase_d;
      coil_q  <= coil_d;
    end
  end

  assign result_o.position   = pos_d;
  assign result_o.coil_drive = coil_d;

  // A load never touches the coils or the phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && item_i.cmd == CMD_LOAD |=> $stable(phase_q) && $stable(coil_q))
    else $error("swdp_core: load changed phase or coils");

  // Wave drive: at most one coil is on at any time.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(coil_q))
    else $error("swdp_core: more than one coil on");

  // A phase move is always a step, which records the item's time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && phase_d != phase_q |=> last_q == $past(item_i.now_ms))
    else $error("swdp_core: phase moved without recording step time");

endmodule

// File: design/stepper_wave_drive_positioner.sv
// ----------------------------------------------------------------------------
// stepper_wave_drive_positioner
// Four-coil wave-drive stepper controller with auto and manual stepping.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Contents
//  s_axis    in         tvalid/tready          step call or position load
//  m_axis    out        tvalid/tready          position and coil pattern
//  cfg       in         cfg_valid/cfg_ready    step_interval_ms
//
//  One item per cycle while the output is not stalled: an item waits in
//  the input register, and its result is computed and stored with the
//  motor state as the item advances into the result register.
//  Reset clears the motor state, the interval and both valid flags.
//  A stalled output holds its result; an empty input register still fills.
// ----------------------------------------------------------------------------
module stepper_wave_drive_positioner (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tdata: now_ms[31:0], target_position[47:32], auto_enable[48],
  //        manual_up[49], new_position[65:50], zero [71:66]
  input  logic [swdp_pkg::InDataW-1:0]        s_axis_tdata,
  // tuser: cmd[0]
  input  logic                                s_axis_tuser,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: position[15:0], coil_drive[19:16], zero [23:20]
  output logic [swdp_pkg::OutDataW-1:0]       m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic [swdp_pkg::IntervalW-1:0]      cfg_data_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o
);
  import swdp_pkg::*;

  swdp_item_t              item_q;
  logic                    in_valid_q;
  swdp_result_t            res_q;
  swdp_result_t            res;
  logic                    out_valid_q;
  logic [IntervalW-1:0]    interval_q;
  logic                    advance;
  logic                    in_xfer;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Interval register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= '0;
    end else if (cfg_valid_i) begin
      interval_q <= cfg_data_i;
    end
  end

  // Input register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // Input payload, unpacked on transfer.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.cmd             <= swdp_cmd_e'(s_axis_tuser);
      item_q.now_ms          <= s_axis_tdata[31:0];
      item_q.target_position <= s_axis_tdata[47:32];
      item_q.auto_enable     <= s_axis_tdata[48];
      item_q.manual_up       <= s_axis_tdata[49];
      item_q.new_position    <= s_axis_tdata[65:50];
    end
  end

  swdp_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .item_i     (item_q),
    .interval_i (interval_q),
    .result_o   (res)
  );

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-PosW-CoilN){1'b0}}, res_q.coil_drive, res_q.position};

endmodule
